// ===== design/lufs_pkg.sv =====
// ----------------------------------------------------------------------------
// lufs_pkg
// Shared types and constants for the LU factor/solve engine.
// ----------------------------------------------------------------------------
package lufs_pkg;

    localparam int MaxOrder = 16;
    localparam int IdxW     = 4;
    localparam int MatAw    = 2 * IdxW;
    localparam int DataW    = 32;
    localparam int FracBits = 16;
    localparam int CntW     = 5;
    localparam int QDepth   = 4;
    localparam int QAw      = 2;

    // op field codes
    localparam logic [2:0] OP_LDM    = 3'd0;
    localparam logic [2:0] OP_FACT   = 3'd1;
    localparam logic [2:0] OP_LDB    = 3'd2;
    localparam logic [2:0] OP_SOLVE  = 3'd3;
    localparam logic [2:0] OP_TSOLVE = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZPIV = 2'd1;
    localparam logic [1:0] STAT_SAT  = 2'd2;

    typedef enum logic [2:0] {
        CMD_LDM,
        CMD_FACT,
        CMD_LDB,
        CMD_SOLVE,
        CMD_TSOLVE
    } t_cmd;

    typedef struct packed {
        t_cmd                    cmd;
        logic [IdxW-1:0]         row;
        logic [IdxW-1:0]         col;
        logic signed [DataW-1:0] value;
    } t_qent;

    typedef struct packed {
        logic                    done;
        logic                    zero;
        logic                    sat;
        logic signed [DataW-1:0] quot;
    } t_div_res;

    typedef enum logic [5:0] {
        S_IDLE,
        S_FA_INIT, S_FA_S0, S_FA_S1, S_FA_SW0, S_FA_SW1, S_FA_SW2, S_FA_PV,
        S_FA_R0, S_FA_R1, S_FA_R2, S_FA_J0, S_FA_J1, S_FA_J2, S_FA_J3, S_FA_R3,
        S_FA_NK, S_FA_L0, S_FA_L1,
        S_SP_F0, S_SP_F1, S_SP_F2, S_SP_FJ, S_SP_F3,
        S_SP_B0, S_SP_B1, S_SP_B2, S_SP_BJ, S_SP_B3, S_SP_B4, S_SP_B5,
        S_TS_F0, S_TS_F1, S_TS_F2, S_TS_FJ, S_TS_F3, S_TS_F4, S_TS_F5,
        S_TS_B0, S_TS_B1, S_TS_B2, S_TS_BJ, S_TS_B3,
        S_TS_P0, S_TS_P1, S_TS_P2,
        S_OUT, S_MS0, S_MS1, S_DV0, S_DV1
    } t_state;

endpackage

// ===== design/lufs_ifs.sv =====
// ----------------------------------------------------------------------------
// lufs_ifs
// Valid/ready channel interfaces for command input and result output.
// ----------------------------------------------------------------------------
interface lufs_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] value;

    modport source (output valid, op, row, col, value, input ready);
    modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface lufs_out_if;
    logic               valid;
    logic               ready;
    logic [3:0]         index;
    logic signed [31:0] result_value;
    logic               last;
    logic [1:0]         status;

    modport source (output valid, index, result_value, last, status, input ready);
    modport sink   (input valid, index, result_value, last, status, output ready);
endinterface

// ===== design/lufs_div.sv =====
// ----------------------------------------------------------------------------
// lufs_div
// Radix-2 restoring divider: (num << FracBits) / den, truncated, saturated.
// ----------------------------------------------------------------------------
module lufs_div (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [lufs_pkg::DataW-1:0]   i_num,
    input  logic signed [lufs_pkg::DataW-1:0]   i_den,
    output lufs_pkg::t_div_res                  o_res
);

    localparam int DvdW = lufs_pkg::DataW + lufs_pkg::FracBits;
    localparam int DW   = lufs_pkg::DataW;

    logic            r_busy;
    logic            r_done;
    logic            r_dz;
    logic            r_neg;
    logic [5:0]      r_cnt;
    logic [DW:0]     r_rem;
    logic [DvdW-1:0] r_dq;
    logic [DW-1:0]   r_den;

    logic [DW-1:0]   s_nmag;
    logic [DW-1:0]   s_dmag;
    logic [DW+1:0]   s_trial;

    assign s_nmag  = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign s_dmag  = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign s_trial = {1'b0, r_rem[DW-1:0], r_dq[DvdW-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != '0);
                r_done <= (i_den == '0);
            end else if (r_busy && r_cnt == 6'(DvdW - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= s_dmag;
            r_dq  <= {s_nmag, {lufs_pkg::FracBits{1'b0}}};
            r_rem <= '0;
            r_neg <= i_num[DW-1] ^ i_den[DW-1];
            r_dz  <= (i_den == '0);
            r_cnt <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 6'd1;
            if (!s_trial[DW+1]) begin
                r_rem <= s_trial[DW:0];
            end else begin
                r_rem <= {r_rem[DW-1:0], r_dq[DvdW-1]};
            end
            r_dq <= {r_dq[DvdW-2:0], ~s_trial[DW+1]};
        end
    end

    always_comb begin
        o_res.done = r_done;
        o_res.zero = r_dz;
        o_res.sat  = 1'b0;
        o_res.quot = '0;
        if (!r_dz) begin
            if (r_neg) begin
                if (r_dq > DvdW'(64'h8000_0000)) begin
                    o_res.sat  = 1'b1;
                    o_res.quot = {1'b1, {(DW-1){1'b0}}};
                end else begin
                    o_res.quot = -r_dq[DW-1:0];
                end
            end else begin
                if (r_dq[DvdW-1:DW-1] != '0) begin
                    o_res.sat  = 1'b1;
                    o_res.quot = {1'b0, {(DW-1){1'b1}}};
                end else begin
                    o_res.quot = r_dq[DW-1:0];
                end
            end
        end
    end

endmodule

// ===== design/lufs_front.sv =====
// ----------------------------------------------------------------------------
// lufs_front
// Input side: accepts commands, decodes op, queues them for the sequencer.
// ----------------------------------------------------------------------------
module lufs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lufs_in_if.sink         i_in,
    input  logic            i_pop,
    output logic            o_qv,
    output lufs_pkg::t_qent o_qent
);

    lufs_pkg::t_qent            r_q [lufs_pkg::QDepth];
    logic [lufs_pkg::QAw-1:0]   r_wp;
    logic [lufs_pkg::QAw-1:0]   r_rp;
    logic [lufs_pkg::QAw:0]     r_cnt;

    logic            s_acc;
    logic            s_push;
    logic            s_pop;
    lufs_pkg::t_qent s_ent;

    assign i_in.ready = (r_cnt != (lufs_pkg::QAw+1)'(lufs_pkg::QDepth));
    assign s_acc      = i_in.valid && i_in.ready;
    assign o_qv       = (r_cnt != '0);
    assign o_qent     = r_q[r_rp];
    assign s_pop      = i_pop && o_qv;

    // unused op codes are dropped here
    always_comb begin
        s_ent.row   = i_in.row;
        s_ent.col   = i_in.col;
        s_ent.value = i_in.value;
        s_push      = s_acc;
        unique case (i_in.op)
            lufs_pkg::OP_LDM:    s_ent.cmd = lufs_pkg::CMD_LDM;
            lufs_pkg::OP_FACT:   s_ent.cmd = lufs_pkg::CMD_FACT;
            lufs_pkg::OP_LDB:    s_ent.cmd = lufs_pkg::CMD_LDB;
            lufs_pkg::OP_SOLVE:  s_ent.cmd = lufs_pkg::CMD_SOLVE;
            lufs_pkg::OP_TSOLVE: s_ent.cmd = lufs_pkg::CMD_TSOLVE;
            default: begin
                s_ent.cmd = lufs_pkg::CMD_LDM;
                s_push    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_q[r_wp] <= s_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) r_wp <= r_wp + 1'b1;
            if (s_pop)  r_rp <= r_rp + 1'b1;
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!s_push && s_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/lufs_back.sv =====
// ----------------------------------------------------------------------------
// lufs_back
// Sequencer: matrix memory, pivot search, elimination and substitution.
// ----------------------------------------------------------------------------
module lufs_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_qv,
    input  lufs_pkg::t_qent               i_qent,
    output logic                          o_pop,
    input  logic [lufs_pkg::CntW-1:0]     i_n,
    lufs_out_if.source                    o_out
);

    localparam int DW = lufs_pkg::DataW;
    localparam int IW = lufs_pkg::IdxW;
    localparam int CW = lufs_pkg::CntW;

    lufs_pkg::t_state r_state, n_state, r_ret;

    logic signed [DW-1:0] r_mat [lufs_pkg::MaxOrder * lufs_pkg::MaxOrder];
    logic signed [DW-1:0] r_mrd;
    logic [IW-1:0]        r_ro  [lufs_pkg::MaxOrder];
    logic signed [DW-1:0] r_rhs [lufs_pkg::MaxOrder];
    logic signed [DW-1:0] r_w   [lufs_pkg::MaxOrder];
    logic signed [DW-1:0] r_lam [lufs_pkg::MaxOrder];

    logic [CW-1:0]        r_k, r_i, r_j;
    logic [IW-1:0]        r_imax, r_rok, r_roi, r_a, r_b;
    logic [DW-1:0]        r_best;
    logic signed [DW-1:0] r_piv, r_m, r_x, r_ma, r_mb;
    logic signed [2*DW-1:0] r_prod;
    logic                 r_sing, r_sat, r_zero;

    logic                 r_ovld, r_olast;
    logic [IW-1:0]        r_oidx;
    logic signed [DW-1:0] r_oval;
    logic [1:0]           r_ost;

    logic [lufs_pkg::MatAw-1:0] s_maddr, s_mwaddr;
    logic                 s_mwe;
    logic signed [DW-1:0] s_mwdata;
    logic [IW-1:0]        s_roidx, s_widx, s_bidx, s_ro, s_nm1;
    logic signed [DW-1:0] s_w, s_b;
    logic                 s_dstart, s_oload;
    logic                 s_in1, s_jn1, s_ji;
    logic [DW-1:0]        s_mag;
    logic signed [2*DW-1:0] s_pr, s_fs;
    logic signed [2*DW:0] s_dif;
    logic signed [DW-1:0] s_msv;
    logic                 s_mss;
    lufs_pkg::t_div_res   s_div;

    assign s_ro  = r_ro[s_roidx];
    assign s_w   = r_w[s_widx];
    assign s_b   = r_rhs[s_bidx];
    assign s_nm1 = IW'(i_n - 1'b1);
    assign s_in1 = (r_i + 1'b1) < i_n;
    assign s_jn1 = (r_j + 1'b1) < i_n;
    assign s_ji  = (r_j + 1'b1) < r_i;
    assign s_mag = r_mrd[DW-1] ? DW'(-r_mrd) : DW'(r_mrd);
    assign o_pop = (r_state == lufs_pkg::S_IDLE) && i_qv;

    // multiply-subtract: round to nearest, ties up, then saturate
    assign s_pr  = r_prod + (64'sd1 <<< (lufs_pkg::FracBits - 1));
    assign s_fs  = s_pr >>> lufs_pkg::FracBits;
    assign s_dif = {{(DW+1){r_x[DW-1]}}, r_x} - {s_fs[2*DW-1], s_fs};
    always_comb begin
        s_mss = 1'b1;
        if (s_dif > 65'sd2147483647) begin
            s_msv = {1'b0, {(DW-1){1'b1}}};
        end else if (s_dif < -65'sd2147483648) begin
            s_msv = {1'b1, {(DW-1){1'b0}}};
        end else begin
            s_msv = s_dif[DW-1:0];
            s_mss = 1'b0;
        end
    end

    lufs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_dstart),
        .i_num   (r_x),
        .i_den   (r_mb),
        .o_res   (s_div)
    );

    // matrix memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (s_mwe) r_mat[s_mwaddr] <= s_mwdata;
        r_mrd <= r_mat[s_maddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lufs_pkg::S_IDLE: begin
                if (i_qv) begin
                    case (i_qent.cmd)
                        lufs_pkg::CMD_FACT:   n_state = lufs_pkg::S_FA_INIT;
                        lufs_pkg::CMD_SOLVE:  n_state = lufs_pkg::S_SP_F0;
                        lufs_pkg::CMD_TSOLVE: n_state = lufs_pkg::S_TS_F0;
                        default:              n_state = lufs_pkg::S_IDLE;
                    endcase
                end
            end
            lufs_pkg::S_FA_INIT: n_state = (i_n == CW'(1)) ? lufs_pkg::S_FA_L0
                                                            : lufs_pkg::S_FA_S0;
            lufs_pkg::S_FA_S0:  n_state = lufs_pkg::S_FA_S1;
            lufs_pkg::S_FA_S1:  n_state = s_in1 ? lufs_pkg::S_FA_S0 : lufs_pkg::S_FA_SW0;
            lufs_pkg::S_FA_SW0: n_state = lufs_pkg::S_FA_SW1;
            lufs_pkg::S_FA_SW1: n_state = lufs_pkg::S_FA_SW2;
            lufs_pkg::S_FA_SW2: n_state = lufs_pkg::S_FA_PV;
            lufs_pkg::S_FA_PV:  n_state = (r_mrd == '0) ? lufs_pkg::S_FA_NK
                                                        : lufs_pkg::S_FA_R0;
            lufs_pkg::S_FA_R0:  n_state = lufs_pkg::S_FA_R1;
            lufs_pkg::S_FA_R1:  n_state = lufs_pkg::S_DV0;
            lufs_pkg::S_FA_R2:  n_state = lufs_pkg::S_FA_J0;
            lufs_pkg::S_FA_J0:  n_state = lufs_pkg::S_FA_J1;
            lufs_pkg::S_FA_J1:  n_state = lufs_pkg::S_FA_J2;
            lufs_pkg::S_FA_J2:  n_state = lufs_pkg::S_MS0;
            lufs_pkg::S_FA_J3:  n_state = s_jn1 ? lufs_pkg::S_FA_J0 : lufs_pkg::S_FA_R3;
            lufs_pkg::S_FA_R3:  n_state = s_in1 ? lufs_pkg::S_FA_R0 : lufs_pkg::S_FA_NK;
            lufs_pkg::S_FA_NK:  n_state = ((r_k + CW'(2)) < i_n) ? lufs_pkg::S_FA_S0
                                                                 : lufs_pkg::S_FA_L0;
            lufs_pkg::S_FA_L0:  n_state = lufs_pkg::S_FA_L1;
            lufs_pkg::S_FA_L1:  n_state = lufs_pkg::S_IDLE;
            lufs_pkg::S_SP_F0:  n_state = (r_i == '0) ? lufs_pkg::S_SP_F3
                                                      : lufs_pkg::S_SP_F1;
            lufs_pkg::S_SP_F1:  n_state = lufs_pkg::S_SP_F2;
            lufs_pkg::S_SP_F2:  n_state = lufs_pkg::S_MS0;
            lufs_pkg::S_SP_FJ:  n_state = s_ji ? lufs_pkg::S_SP_F1 : lufs_pkg::S_SP_F3;
            lufs_pkg::S_SP_F3:  n_state = s_in1 ? lufs_pkg::S_SP_F0 : lufs_pkg::S_SP_B0;
            lufs_pkg::S_SP_B0:  n_state = s_in1 ? lufs_pkg::S_SP_B1 : lufs_pkg::S_SP_B3;
            lufs_pkg::S_SP_B1:  n_state = lufs_pkg::S_SP_B2;
            lufs_pkg::S_SP_B2:  n_state = lufs_pkg::S_MS0;
            lufs_pkg::S_SP_BJ:  n_state = s_jn1 ? lufs_pkg::S_SP_B1 : lufs_pkg::S_SP_B3;
            lufs_pkg::S_SP_B3:  n_state = lufs_pkg::S_SP_B4;
            lufs_pkg::S_SP_B4:  n_state = lufs_pkg::S_DV0;
            lufs_pkg::S_SP_B5:  n_state = (r_i == '0) ? lufs_pkg::S_OUT
                                                      : lufs_pkg::S_SP_B0;
            lufs_pkg::S_TS_F0:  n_state = (r_i == '0) ? lufs_pkg::S_TS_F3
                                                      : lufs_pkg::S_TS_F1;
            lufs_pkg::S_TS_F1:  n_state = lufs_pkg::S_TS_F2;
            lufs_pkg::S_TS_F2:  n_state = lufs_pkg::S_MS0;
            lufs_pkg::S_TS_FJ:  n_state = s_ji ? lufs_pkg::S_TS_F1 : lufs_pkg::S_TS_F3;
            lufs_pkg::S_TS_F3:  n_state = lufs_pkg::S_TS_F4;
            lufs_pkg::S_TS_F4:  n_state = lufs_pkg::S_DV0;
            lufs_pkg::S_TS_F5:  n_state = s_in1 ? lufs_pkg::S_TS_F0 : lufs_pkg::S_TS_B0;
            lufs_pkg::S_TS_B0:  n_state = s_in1 ? lufs_pkg::S_TS_B1 : lufs_pkg::S_TS_B3;
            lufs_pkg::S_TS_B1:  n_state = lufs_pkg::S_TS_B2;
            lufs_pkg::S_TS_B2:  n_state = lufs_pkg::S_MS0;
            lufs_pkg::S_TS_BJ:  n_state = s_jn1 ? lufs_pkg::S_TS_B1 : lufs_pkg::S_TS_B3;
            lufs_pkg::S_TS_B3:  n_state = (r_i == '0) ? lufs_pkg::S_TS_P0
                                                      : lufs_pkg::S_TS_B0;
            lufs_pkg::S_TS_P0:  n_state = lufs_pkg::S_TS_P1;
            lufs_pkg::S_TS_P1:  n_state = s_in1 ? lufs_pkg::S_TS_P1 : lufs_pkg::S_TS_P2;
            lufs_pkg::S_TS_P2:  n_state = s_in1 ? lufs_pkg::S_TS_P2 : lufs_pkg::S_OUT;
            lufs_pkg::S_OUT: begin
                if (s_oload && !s_in1) n_state = lufs_pkg::S_IDLE;
            end
            lufs_pkg::S_MS0:    n_state = lufs_pkg::S_MS1;
            lufs_pkg::S_MS1:    n_state = r_ret;
            lufs_pkg::S_DV0:    n_state = lufs_pkg::S_DV1;
            lufs_pkg::S_DV1:    n_state = s_div.done ? r_ret : lufs_pkg::S_DV1;
            default:            n_state = lufs_pkg::S_IDLE;
        endcase
    end

    // addresses and strobes
    always_comb begin
        s_maddr  = '0;
        s_roidx  = r_i[IW-1:0];
        s_widx   = r_i[IW-1:0];
        s_bidx   = r_i[IW-1:0];
        s_mwe    = 1'b0;
        s_mwaddr = {r_roi, r_j[IW-1:0]};
        s_mwdata = r_x;
        s_dstart = 1'b0;
        s_oload  = 1'b0;
        unique case (r_state)
            lufs_pkg::S_IDLE: begin
                s_mwe    = i_qv && (i_qent.cmd == lufs_pkg::CMD_LDM);
                s_mwaddr = {i_qent.row, i_qent.col};
                s_mwdata = i_qent.value;
            end
            lufs_pkg::S_FA_S0:  s_maddr = {s_ro, r_k[IW-1:0]};
            lufs_pkg::S_FA_SW0: s_roidx = r_imax;
            lufs_pkg::S_FA_SW1: s_roidx = r_k[IW-1:0];
            lufs_pkg::S_FA_SW2: s_maddr = {r_rok, r_k[IW-1:0]};
            lufs_pkg::S_FA_R0:  s_maddr = {s_ro, r_k[IW-1:0]};
            lufs_pkg::S_FA_J0:  s_maddr = {r_rok, r_j[IW-1:0]};
            lufs_pkg::S_FA_J1:  s_maddr = {r_roi, r_j[IW-1:0]};
            lufs_pkg::S_FA_J3:  s_mwe   = 1'b1;
            lufs_pkg::S_FA_R3: begin
                s_mwe    = 1'b1;
                s_mwaddr = {r_roi, r_k[IW-1:0]};
                s_mwdata = r_m;
            end
            lufs_pkg::S_FA_L0: begin
                s_roidx = s_nm1;
                s_maddr = {s_ro, s_nm1};
            end
            lufs_pkg::S_SP_F0:  s_bidx  = s_ro;
            lufs_pkg::S_SP_F1:  s_maddr = {r_roi, r_j[IW-1:0]};
            lufs_pkg::S_SP_F2:  s_widx  = r_j[IW-1:0];
            lufs_pkg::S_SP_B1:  s_maddr = {r_roi, r_j[IW-1:0]};
            lufs_pkg::S_SP_B2:  s_widx  = r_j[IW-1:0];
            lufs_pkg::S_SP_B3:  s_maddr = {r_roi, r_i[IW-1:0]};
            lufs_pkg::S_TS_F1: begin
                s_roidx = r_j[IW-1:0];
                s_maddr = {s_ro, r_i[IW-1:0]};
            end
            lufs_pkg::S_TS_F2:  s_widx  = r_j[IW-1:0];
            lufs_pkg::S_TS_F3:  s_maddr = {s_ro, r_i[IW-1:0]};
            lufs_pkg::S_TS_B1: begin
                s_roidx = r_j[IW-1:0];
                s_maddr = {s_ro, r_i[IW-1:0]};
            end
            lufs_pkg::S_TS_B2:  s_widx  = r_j[IW-1:0];
            lufs_pkg::S_OUT:    s_oload = !r_ovld || o_out.ready;
            lufs_pkg::S_DV0:    s_dstart = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lufs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // row order and singular flag: reset to identity / clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sing <= 1'b0;
            for (int g = 0; g < lufs_pkg::MaxOrder; g++) r_ro[g] <= IW'(g);
        end else begin
            unique case (r_state)
                lufs_pkg::S_FA_INIT: begin
                    r_sing <= 1'b0;
                    for (int g = 0; g < lufs_pkg::MaxOrder; g++) r_ro[g] <= IW'(g);
                end
                lufs_pkg::S_FA_SW1: r_ro[r_k[IW-1:0]] <= r_a;
                lufs_pkg::S_FA_SW2: r_ro[r_imax] <= r_b;
                lufs_pkg::S_FA_PV:  if (r_mrd == '0) r_sing <= 1'b1;
                lufs_pkg::S_FA_L1:  if (r_mrd == '0) r_sing <= 1'b1;
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            lufs_pkg::S_IDLE: begin
                if (i_qv) begin
                    if (i_qent.cmd == lufs_pkg::CMD_LDB) r_rhs[i_qent.row] <= i_qent.value;
                    r_i    <= '0;
                    r_sat  <= 1'b0;
                    r_zero <= 1'b0;
                end
            end
            lufs_pkg::S_FA_INIT: begin
                r_k <= '0;
                r_i <= '0;
            end
            lufs_pkg::S_FA_S1: begin
                if (r_i == r_k || r_best < s_mag) begin
                    r_best <= s_mag;
                    r_imax <= r_i[IW-1:0];
                end
                r_i <= r_i + 1'b1;
            end
            lufs_pkg::S_FA_SW0: r_a <= s_ro;
            lufs_pkg::S_FA_SW1: begin
                r_b   <= s_ro;
                r_rok <= r_a;
            end
            lufs_pkg::S_FA_PV: begin
                r_piv <= r_mrd;
                r_i   <= r_k + 1'b1;
            end
            lufs_pkg::S_FA_R0: r_roi <= s_ro;
            lufs_pkg::S_FA_R1: begin
                r_x   <= r_mrd;
                r_mb  <= r_piv;
                r_ret <= lufs_pkg::S_FA_R2;
            end
            lufs_pkg::S_FA_R2: begin
                r_m <= r_x;
                r_j <= r_k + 1'b1;
            end
            lufs_pkg::S_FA_J1: begin
                r_mb <= r_mrd;
                r_ma <= r_m;
            end
            lufs_pkg::S_FA_J2: begin
                r_x   <= r_mrd;
                r_ret <= lufs_pkg::S_FA_J3;
            end
            lufs_pkg::S_FA_J3: r_j <= r_j + 1'b1;
            lufs_pkg::S_FA_R3: r_i <= r_i + 1'b1;
            lufs_pkg::S_FA_NK: begin
                r_k <= r_k + 1'b1;
                r_i <= r_k + 1'b1;
            end
            lufs_pkg::S_SP_F0: begin
                r_roi <= s_ro;
                r_x   <= s_b;
                r_j   <= '0;
            end
            lufs_pkg::S_SP_F2, lufs_pkg::S_SP_B2,
            lufs_pkg::S_TS_F2, lufs_pkg::S_TS_B2: begin
                r_ma <= r_mrd;
                r_mb <= s_w;
                unique case (r_state)
                    lufs_pkg::S_SP_F2: r_ret <= lufs_pkg::S_SP_FJ;
                    lufs_pkg::S_SP_B2: r_ret <= lufs_pkg::S_SP_BJ;
                    lufs_pkg::S_TS_F2: r_ret <= lufs_pkg::S_TS_FJ;
                    default:           r_ret <= lufs_pkg::S_TS_BJ;
                endcase
            end
            lufs_pkg::S_SP_FJ, lufs_pkg::S_SP_BJ,
            lufs_pkg::S_TS_FJ, lufs_pkg::S_TS_BJ: r_j <= r_j + 1'b1;
            lufs_pkg::S_SP_F3, lufs_pkg::S_TS_F5: begin
                r_w[r_i[IW-1:0]] <= r_x;
                r_i <= s_in1 ? r_i + 1'b1 : i_n - 1'b1;
            end
            lufs_pkg::S_SP_B0: begin
                r_x   <= s_w;
                r_roi <= s_ro;
                r_j   <= r_i + 1'b1;
            end
            lufs_pkg::S_SP_B4, lufs_pkg::S_TS_F4: begin
                r_mb  <= r_mrd;
                r_ret <= (r_state == lufs_pkg::S_SP_B4) ? lufs_pkg::S_SP_B5
                                                        : lufs_pkg::S_TS_F5;
            end
            lufs_pkg::S_SP_B5, lufs_pkg::S_TS_B3: begin
                r_w[r_i[IW-1:0]] <= r_x;
                if (r_i != '0) r_i <= r_i - 1'b1;
            end
            lufs_pkg::S_TS_F0: begin
                r_x <= s_b;
                r_j <= '0;
            end
            lufs_pkg::S_TS_B0: begin
                r_x <= s_w;
                r_j <= r_i + 1'b1;
            end
            lufs_pkg::S_TS_P0: begin
                for (int g = 0; g < lufs_pkg::MaxOrder; g++) r_lam[g] <= '0;
                r_i <= '0;
            end
            lufs_pkg::S_TS_P1: begin
                r_lam[s_ro] <= s_w;
                r_i <= s_in1 ? r_i + 1'b1 : '0;
            end
            lufs_pkg::S_TS_P2: begin
                r_w[r_i[IW-1:0]] <= r_lam[r_i[IW-1:0]];
                r_i <= s_in1 ? r_i + 1'b1 : '0;
            end
            lufs_pkg::S_OUT: if (s_oload) r_i <= r_i + 1'b1;
            lufs_pkg::S_MS0: r_prod <= r_ma * r_mb;
            lufs_pkg::S_MS1: begin
                r_x   <= s_msv;
                r_sat <= r_sat | s_mss;
            end
            lufs_pkg::S_DV1: begin
                if (s_div.done) begin
                    r_x    <= s_div.quot;
                    r_sat  <= r_sat | s_div.sat;
                    r_zero <= r_zero | s_div.zero;
                end
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (s_oload) begin
            r_ovld <= 1'b1;
        end else if (o_out.ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_oload) begin
            r_oidx  <= r_i[IW-1:0];
            r_oval  <= s_w;
            r_olast <= !s_in1;
            r_ost   <= (r_sing || r_zero) ? lufs_pkg::STAT_ZPIV
                     : (r_sat ? lufs_pkg::STAT_SAT : lufs_pkg::STAT_OK);
        end
    end

    assign o_out.valid        = r_ovld;
    assign o_out.index        = r_oidx;
    assign o_out.result_value = r_oval;
    assign o_out.last         = r_olast;
    assign o_out.status       = r_ost;

    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lufs_pkg::S_OUT) |-> (r_i < i_n))
        else $error("result index past order");

    a_srch_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lufs_pkg::S_FA_S1) |-> (r_i < i_n && r_i >= r_k))
        else $error("pivot search out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !o_out.ready) |=> r_ovld)
        else $error("pending result dropped");

endmodule

// ===== design/lu_factor_solve_engine.sv =====
// ----------------------------------------------------------------------------
// lu_factor_solve_engine
// LU factorization with partial pivoting and forward/back solve, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : command channel (valid/ready). op selects load matrix entry,
//           factor, load rhs entry, solve, or transposed solve. Codes 5-7
//           are dropped with no result.
//   o_out : result channel (valid/ready). A solve gives n transfers, index 0
//           first, last set on the final one; status is the same on all.
//   APB   : register 0 at byte address 0 holds size_in_use (order n,
//           0 acts as 1, above 16 acts as 16). Write only while idle.
// Throughput: loads drain at one per cycle, while the sequencer is idle,
//   through a 4-entry command queue. Factor and solve occupy the
//   sequencer: each multiply-subtract takes a memory read, a multiply and
//   a round/saturate step, and each divide runs the 48-step restoring
//   divider. The queue keeps accepting loads while a command runs.
// Reset: synchronous, active low. Row order becomes identity, the singular
//   flag clears, size_in_use returns to 16. Matrix and rhs are undefined.
// Stall: a result waits in the output register; the sequencer holds until
//   it is taken, the queue still fills behind it.
// ----------------------------------------------------------------------------
module lu_factor_solve_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lufs_in_if.sink     i_in,
    lufs_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW = lufs_pkg::CntW;

    logic [CW-1:0]   r_size;
    logic [CW-1:0]   s_n;
    logic            s_qv;
    logic            s_pop;
    lufs_pkg::t_qent s_qent;

    // config register
    assign pready = 1'b1;
    assign prdata = {{(32-CW){1'b0}}, r_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= CW'(lufs_pkg::MaxOrder);
        end else if (psel && penable && pwrite && paddr == 2'd0) begin
            r_size <= pwdata[CW-1:0];
        end
    end

    // clamp order to [1, MaxOrder]
    always_comb begin
        if (r_size == '0) begin
            s_n = CW'(1);
        end else if (r_size > CW'(lufs_pkg::MaxOrder)) begin
            s_n = CW'(lufs_pkg::MaxOrder);
        end else begin
            s_n = r_size;
        end
    end

    lufs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_pop   (s_pop),
        .o_qv    (s_qv),
        .o_qent  (s_qent)
    );

    lufs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qv    (s_qv),
        .i_qent  (s_qent),
        .o_pop   (s_pop),
        .i_n     (s_n),
        .o_out   (o_out)
    );

endmodule

// ===== tb/sv/tb_lu_factor_solve_engine.sv =====
// ----------------------------------------------------------------------------
// tb_lu_factor_solve_engine
// Self-checking bench: loads matrices and right-hand sides, factors, runs
// plain and transposed solves under random stalls, checks every solution.
// ----------------------------------------------------------------------------
module tb_lu_factor_solve_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import lufs_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    lufs_in_if  in_if ();
    lufs_out_if out_if ();

    lu_factor_solve_engine dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    localparam logic [1:0] REG_SIZE_ADDR = 2'd0;  // size_in_use, register 0
    localparam logic [2:0] OP_UNUSED5    = 3'd5;
    localparam logic [2:0] OP_UNUSED7    = 3'd7;

    typedef struct {
        logic [3:0]         index;
        logic signed [31:0] value;
        logic               last;
        logic [1:0]         status;
    } t_solution;

    // ------------------------------------------------------------------------
    // Predictor state: own copy of matrix, rhs, row order and size register
    // ------------------------------------------------------------------------
    logic signed [31:0] lu_mat [MaxOrder][MaxOrder];
    logic signed [31:0] rhs_vec [MaxOrder];
    logic signed [31:0] work_vec [MaxOrder];
    logic [3:0]         row_perm [MaxOrder];
    bit                 singular;
    logic [4:0]         order_reg;
    bit                 saw_sat;
    bit                 saw_zero_div;

    t_solution expected_solution [$];

    int tx_idle_pct;
    int rx_idle_pct;
    int fail_count;
    int items_sent;
    int solves_sent;
    int results_seen;
    int cfg_writes;

    // ------------------------------------------------------------------------
    // Fixed-point arithmetic, Q16.16 with saturation
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) begin
            saw_sat = 1;
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            saw_sat = 1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // x - round(a*b), round half toward +inf via add then floor shift
    function automatic logic signed [31:0] fx_msub(logic signed [31:0] x,
                                                   logic signed [31:0] a,
                                                   logic signed [31:0] b);
        longint pr;
        pr = longint'(a) * longint'(b) + (64'sd1 <<< (FracBits - 1));
        return clip32(longint'(x) - (pr >>> FracBits));
    endfunction

    function automatic logic signed [31:0] fx_quot(logic signed [31:0] a,
                                                   logic signed [31:0] b);
        if (b == 0) begin
            saw_zero_div = 1;
            return 0;
        end
        return clip32((longint'(a) <<< FracBits) / longint'(b));
    endfunction

    function automatic longint abs64(logic signed [31:0] v);
        longint w;
        w = longint'(v);
        return (w < 0) ? -w : w;
    endfunction

    function automatic int active_order();
        if (order_reg < 1) return 1;
        if (order_reg > MaxOrder) return MaxOrder;
        return int'(order_reg);
    endfunction

    // In-place LU with partial pivoting; rows stay put, row_perm tracks order
    function automatic void lu_factorize(int n);
        int imax;
        longint best;
        longint m;
        logic [3:0] t;
        logic signed [31:0] piv;
        logic signed [31:0] mlt;
        for (int i = 0; i < MaxOrder; i++) row_perm[i] = i[3:0];
        singular = 0;
        for (int k = 0; k + 1 < n; k++) begin
            imax = k;
            best = abs64(lu_mat[row_perm[k]][k]);
            for (int i = k + 1; i < n; i++) begin
                m = abs64(lu_mat[row_perm[i]][k]);
                if (best < m) begin
                    best = m;
                    imax = i;
                end
            end
            t = row_perm[k];
            row_perm[k] = row_perm[imax];
            row_perm[imax] = t;
            piv = lu_mat[row_perm[k]][k];
            if (piv == 0) begin
                singular = 1;
                continue;
            end
            for (int i = k + 1; i < n; i++) begin
                mlt = fx_quot(lu_mat[row_perm[i]][k], piv);
                for (int j = k + 1; j < n; j++)
                    lu_mat[row_perm[i]][j] = fx_msub(lu_mat[row_perm[i]][j], mlt,
                                                     lu_mat[row_perm[k]][j]);
                lu_mat[row_perm[i]][k] = mlt;
            end
        end
        if (lu_mat[row_perm[n-1]][n-1] == 0) singular = 1;
    endfunction

    function automatic void lu_solve_plain(int n);
        logic signed [31:0] x;
        for (int i = 0; i < n; i++) begin
            x = rhs_vec[row_perm[i]];
            for (int j = 0; j < i; j++) x = fx_msub(x, lu_mat[row_perm[i]][j], work_vec[j]);
            work_vec[i] = x;
        end
        for (int i = n - 1; i >= 0; i--) begin
            x = work_vec[i];
            for (int j = i + 1; j < n; j++)
                x = fx_msub(x, lu_mat[row_perm[i]][j], work_vec[j]);
            work_vec[i] = fx_quot(x, lu_mat[row_perm[i]][i]);
        end
    endfunction

    function automatic void lu_solve_trans(int n);
        logic signed [31:0] y;
        logic signed [31:0] unperm [MaxOrder];
        for (int i = 0; i < n; i++) begin
            y = rhs_vec[i];
            for (int j = 0; j < i; j++) y = fx_msub(y, lu_mat[row_perm[j]][i], work_vec[j]);
            work_vec[i] = fx_quot(y, lu_mat[row_perm[i]][i]);
        end
        for (int i = n - 1; i >= 0; i--) begin
            y = work_vec[i];
            for (int j = i + 1; j < n; j++)
                y = fx_msub(y, lu_mat[row_perm[j]][i], work_vec[j]);
            work_vec[i] = y;
        end
        for (int i = 0; i < MaxOrder; i++) unperm[i] = 0;
        for (int i = 0; i < n; i++) unperm[row_perm[i]] = work_vec[i];
        for (int i = 0; i < n; i++) work_vec[i] = unperm[i];
    endfunction

    // Applies one accepted command; solves queue their n expected results
    function automatic void predict_command(logic [2:0] op, logic [3:0] row,
                                            logic [3:0] col, logic signed [31:0] val);
        int n;
        t_solution s;
        logic [1:0] st;
        n = active_order();
        case (op)
            OP_LDM:   lu_mat[row][col] = val;
            OP_LDB:   rhs_vec[row] = val;
            OP_FACT:  lu_factorize(n);
            OP_SOLVE, OP_TSOLVE: begin
                saw_sat = 0;
                saw_zero_div = 0;
                if (op == OP_SOLVE) lu_solve_plain(n);
                else lu_solve_trans(n);
                st = (singular || saw_zero_div) ? STAT_ZPIV : (saw_sat ? STAT_SAT : STAT_OK);
                for (int k = 0; k < n; k++) begin
                    s.index  = k[3:0];
                    s.value  = work_vec[k];
                    s.last   = (k + 1 == n);
                    s.status = st;
                    expected_solution.push_back(s);
                end
            end
            default: ;  // unused codes are dropped
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $display("timeout: %0d solutions still pending", expected_solution.size());
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and in-order compare
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_solution e;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            results_seen++;
            if (expected_solution.size() == 0) begin
                $error("unexpected result transfer index=%0d value=%0d",
                       out_if.index, out_if.result_value);
                fail_count++;
            end else begin
                e = expected_solution.pop_front();
                if (out_if.index !== e.index) begin
                    $error("index: expected %0d, got %0d", e.index, out_if.index);
                    fail_count++;
                end
                if (out_if.result_value !== e.value) begin
                    $error("result_value: expected %0d, got %0d", e.value,
                           out_if.result_value);
                    fail_count++;
                end
                if (out_if.last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, out_if.last);
                    fail_count++;
                end
                if (out_if.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, out_if.status);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // One command transfer; random gap first, prediction at acceptance
    task automatic send_command(logic [2:0] op, logic [3:0] row, logic [3:0] col,
                                logic signed [31:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_if.valid <= 0;
            in_if.value <= $urandom;
            @(posedge i_clk);
        end
        in_if.valid <= 1;
        in_if.op    <= op;
        in_if.row   <= row;
        in_if.col   <= col;
        in_if.value <= val;
        do @(posedge i_clk); while (!in_if.ready);
        predict_command(op, row, col, val);
        items_sent++;
        if (op == OP_SOLVE || op == OP_TSOLVE) solves_sent++;
    endtask

    // Drain all results, then a short settle before touching the register
    task automatic wait_idle();
        in_if.valid <= 0;
        @(posedge i_clk);
        while (expected_solution.size() != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    // APB setup + access; upper data bits are junk to exercise the mask
    task automatic set_order(logic [4:0] n);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= REG_SIZE_ADDR;
        pwdata  <= {$urandom_range(0, 32'h07ffffff), n};
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        order_reg = n;
        cfg_writes++;
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
    endtask

    // Random entry: mostly a few units in Q16.16, sometimes full range
    function automatic logic signed [31:0] pick_value(int style);
        case (style)
            0:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            1:       return $urandom;
            default: return ($urandom_range(3) == 0) ? 0 :
                            $signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000;
        endcase
    endfunction

    // Full load of an n x n system, factor, then one to three solves
    task automatic run_system(int n, int style);
        logic signed [31:0] v;
        int zcol;
        zcol = (style == 2) ? $urandom_range(n - 1) : -1;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                v = pick_value(style);
                if (c == zcol) v = 0;
                else if (r == c && style == 0) v = v + (($urandom_range(1)) ?
                                                        32'sh0008_0000 : -32'sh0008_0000);
                send_command(OP_LDM, r[3:0], c[3:0], v);
                if ($urandom_range(19) == 0)  // stray command that must be ignored
                    send_command($urandom_range(OP_UNUSED5, OP_UNUSED7), $urandom,
                                 $urandom, $urandom);
            end
        for (int r = 0; r < n; r++) send_command(OP_LDB, r[3:0], 0, pick_value(style % 2));
        send_command(OP_FACT, $urandom, $urandom, $urandom);
        repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(2) == 0)
                send_command(OP_LDB, $urandom_range(n - 1), $urandom, pick_value(1));
            send_command($urandom_range(1) ? OP_SOLVE : OP_TSOLVE, $urandom, $urandom,
                         $urandom);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Order 2 with pivot swap and extreme rhs, dropped op codes, order 1 via
    // size 0, zero pivot, and the corner entries of the arrays
    task automatic test_directed();
        set_order(5'd2);
        send_command(OP_LDM, 0, 0, 0);
        send_command(OP_LDM, 0, 1, 32'sh0001_0000);
        send_command(OP_LDM, 1, 0, 32'sh0002_0000);
        send_command(OP_LDM, 1, 1, -32'sh0000_8000);
        send_command(OP_LDB, 0, 0, 32'sh7fffffff);
        send_command(OP_LDB, 1, 0, 32'sh80000000);
        send_command(OP_LDM, 15, 15, 32'shffffffff);
        send_command(OP_LDB, 15, 15, 32'sh5a5a5a5a);
        send_command(OP_FACT, 0, 0, 0);
        send_command(OP_SOLVE, 0, 0, 0);
        send_command(OP_TSOLVE, 15, 15, 32'shffffffff);
        send_command(OP_UNUSED5, 1, 1, 32'sh1234_5678);
        send_command(3'd6, 15, 15, 32'shffffffff);
        send_command(OP_UNUSED7, 0, 0, 0);
        wait_idle();
        set_order(5'd0);  // acts as order 1
        send_command(OP_LDM, 0, 0, 32'sh0000_0001);
        send_command(OP_LDB, 0, 0, 32'sh7fffffff);
        send_command(OP_FACT, 0, 0, 0);
        send_command(OP_SOLVE, 0, 0, 0);
        send_command(OP_LDM, 0, 0, 0);
        send_command(OP_FACT, 0, 0, 0);
        send_command(OP_TSOLVE, 0, 0, 0);
        wait_idle();
    endtask

    // One idling pattern: small systems at changing orders until the item
    // budget is used; big_one adds a single full-size system via size 31
    task automatic test_random(int tx_pct, int rx_pct, int budget, bit big_one);
        int stop_at;
        int n;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            n = $urandom_range(1, 5);
            set_order(n[4:0]);
            repeat ($urandom_range(1, 2)) run_system(n, $urandom_range(9) < 6 ? 0 :
                                                     $urandom_range(1, 2));
            wait_idle();
        end
        if (big_one) begin
            set_order(5'd31);
            run_system(MaxOrder, 0);
            wait_idle();
            set_order(5'd16);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n      = 0;
        psel         = 0;
        penable      = 0;
        pwrite       = 0;
        paddr        = 0;
        pwdata       = 0;
        in_if.valid  = 0;
        in_if.op     = 0;
        in_if.row    = 0;
        in_if.col    = 0;
        in_if.value  = 0;
        out_if.ready = 0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        fail_count   = 0;
        items_sent   = 0;
        solves_sent  = 0;
        results_seen = 0;
        cfg_writes   = 0;
        order_reg    = 5'd16;
        singular     = 0;
        for (int i = 0; i < MaxOrder; i++) begin
            row_perm[i] = i[3:0];
            rhs_vec[i]  = 0;
            work_vec[i] = 0;
            for (int j = 0; j < MaxOrder; j++) lu_mat[i][j] = 0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        test_directed();
        test_random(12, 70, 100, 0);
        test_random(70, 12, 100, 0);
        test_random(0, 0, 60, 1);

        in_if.valid <= 0;
        while (expected_solution.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Run: %0d command transfers (%0d solves), %0d result transfers,",
                 items_sent, solves_sent, results_seen);
        $display("     %0d size register writes across orders 0..31.", cfg_writes);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
